// ===== hw/rtl/bdlm_pkg.sv =====
// Package for the Bayer demosaic block with label mask.
// Holds the item structs, geometry constants, the stage control struct and small
// arithmetic helpers. Depends on nothing.
package bdlm_pkg;

	localparam int MaxWidth  = 1024;
	localparam int MaxHeight = 1024;
	localparam int AddrW     = $clog2(MaxWidth);
	localparam int GeoW      = 11;
	localparam int RowW      = 11;
	localparam int CfgAddrW  = 3;
	localparam int WordW     = 9;

	localparam logic [GeoW-1:0] ResetWidth  = GeoW'(640);
	localparam logic [GeoW-1:0] ResetHeight = GeoW'(480);

	localparam logic RegFrameWidth  = 1'b0;
	localparam logic RegFrameHeight = 1'b1;

	typedef struct packed {
		logic        mode;
		logic [7:0]  raw_sample;
		logic [15:0] scene_label;
	} in_item_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       frame_end;
	} out_item_t;

	typedef enum logic [1:0] {
		EMIT_NONE,
		EMIT_LAST,
		EMIT_CUR
	} emit_t;

	typedef enum logic {
		MODE_SAMPLE,
		MODE_DRAIN
	} mode_t;

	typedef struct packed {
		logic             step;
		logic             store;
		logic             par;
		logic [AddrW-1:0] addr;
		logic [7:0]       bottom;
		logic             label_on;
		logic             top_ok;
		logic             mid_ok;
		emit_t            emit;
		logic             y_odd;
		logic             x_odd;
		logic             top;
		logic             bot;
		logic             lft;
		logic             rgt;
		logic             frame_end;
	} stage_t;

	function automatic logic [GeoW-1:0] clamp_geo(input logic [GeoW-1:0] v,
		input logic [GeoW-1:0] vmax);
		logic [GeoW-1:0] t;
		t = v;
		if (t > vmax) begin
			t = vmax;
		end
		if (t < GeoW'(4)) begin
			t = GeoW'(4);
		end
		return {t[GeoW-1:1], 1'b0};
	endfunction

	function automatic logic [7:0] avg2(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[8:1];
	endfunction

	function automatic logic [7:0] avg4(input logic [7:0] a, input logic [7:0] b,
		input logic [7:0] c, input logic [7:0] d);
		logic [9:0] s;
		s = {2'b0, a} + {2'b0, b} + {2'b0, c} + {2'b0, d};
		return s[9:2];
	endfunction

	// Division by three through a reciprocal; exact for sums up to 765.
	function automatic logic [7:0] avg3(input logic [7:0] a, input logic [7:0] b,
		input logic [7:0] c);
		logic [9:0]  s;
		logic [20:0] p;
		s = {2'b0, a} + {2'b0, b} + {2'b0, c};
		p = {11'b0, s} * 21'd683;
		return p[18:11];
	endfunction

endpackage

// ===== hw/rtl/bayer_demosaic_with_label_mask.sv =====
// Top level of the GRBG bilinear demosaic with label mask.
// Holds the configuration registers and the two line-store banks; instantiates
// bdlm_seq, bdlm_interp and bdlm_ram. Depends on bdlm_pkg.

// The block takes one item per clock cycle and gives each pixel after the item that
// completes its window, via the control and output registers. Pixels lag the input
// position by one row and one column; drain items push out the last row of a frame.
// Line stores are two row banks, each one read and one write per cycle at the current
// column, which sets the rate. Geometry is latched on each frame's first sample.
// When the output is stalled the whole pipeline holds and the input is stalled.
module bayer_demosaic_with_label_mask (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  bdlm_pkg::in_item_t            in_item,
	output logic                          out_valid,
	input  logic                          out_stall,
	output bdlm_pkg::out_item_t           out_item,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bdlm_pkg::CfgAddrW-1:0] paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import bdlm_pkg::*;

	logic [GeoW-1:0]  width_q;
	logic [GeoW-1:0]  height_q;
	logic             en;
	logic [AddrW-1:0] rd_addr;
	logic             v_s1;
	stage_t           ctl_s1;
	logic [WordW-1:0] rd0;
	logic [WordW-1:0] rd1;
	logic             we0;
	logic             we1;
	logic [WordW-1:0] wdata;

	assign pready   = 1'b1;
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= ResetWidth;
			height_q <= ResetHeight;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				RegFrameWidth:  width_q  <= pwdata[GeoW-1:0];
				RegFrameHeight: height_q <= pwdata[GeoW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			RegFrameWidth:  prdata = {{(32-GeoW){1'b0}}, width_q};
			RegFrameHeight: prdata = {{(32-GeoW){1'b0}}, height_q};
			default:        prdata = '0;
		endcase
	end

	bdlm_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (in_valid),
		.in_item    (in_item),
		.cfg_width  (width_q),
		.cfg_height (height_q),
		.rd_addr    (rd_addr),
		.v_s1       (v_s1),
		.ctl_s1     (ctl_s1)
	);

	bdlm_ram #(.Width(WordW), .Depth(MaxWidth)) u_bank0 (
		.clk   (clk),
		.we    (we0),
		.waddr (ctl_s1.addr),
		.wdata (wdata),
		.re    (en),
		.raddr (rd_addr),
		.rdata (rd0)
	);

	bdlm_ram #(.Width(WordW), .Depth(MaxWidth)) u_bank1 (
		.clk   (clk),
		.we    (we1),
		.waddr (ctl_s1.addr),
		.wdata (wdata),
		.re    (en),
		.raddr (rd_addr),
		.rdata (rd1)
	);

	bdlm_interp u_interp (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.v_s1      (v_s1),
		.ctl_s1    (ctl_s1),
		.rd0       (rd0),
		.rd1       (rd1),
		.we0       (we0),
		.we1       (we1),
		.wdata     (wdata),
		.out_valid (out_valid),
		.out_item  (out_item)
	);

endmodule

// ===== hw/rtl/bdlm_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read.
// The read data holds while the read enable is low. No dependencies.
module bdlm_ram #(
	parameter int Width = 8,
	parameter int Depth = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/bdlm_seq.sv =====
// Input sequencer: raster counters, frame geometry latch and per-item decode.
// Issues the line-store read address and registers the stage control.
// Depends on bdlm_pkg.
module bdlm_seq (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  bdlm_pkg::in_item_t        in_item,
	input  logic [bdlm_pkg::GeoW-1:0] cfg_width,
	input  logic [bdlm_pkg::GeoW-1:0] cfg_height,
	output logic [bdlm_pkg::AddrW-1:0] rd_addr,
	output logic                      v_s1,
	output bdlm_pkg::stage_t          ctl_s1
);
	import bdlm_pkg::*;

	logic [RowW-1:0]  in_row_q;
	logic [AddrW-1:0] in_column_q;
	logic [GeoW-1:0]  cur_w_q;
	logic [GeoW-1:0]  cur_h_q;

	logic             accept;
	logic             is_sample;
	logic [RowW-1:0]  r;
	logic [AddrW-1:0] c;
	logic             new_frame;
	logic [GeoW-1:0]  w;
	logic [GeoW-1:0]  h;
	logic             do_step;
	logic             last_emit;
	logic [GeoW-1:0]  y;
	logic [GeoW-1:0]  x;
	logic [GeoW-1:0]  c_next;
	logic [RowW-1:0]  row_nx;
	logic [AddrW-1:0] col_nx;
	stage_t           ctl;

	assign accept    = in_valid && en;
	assign is_sample = (in_item.mode == MODE_SAMPLE);

	always_comb begin
		if (is_sample && (in_row_q >= cur_h_q)) begin
			r = '0;
			c = '0;
		end else begin
			r = in_row_q;
			c = in_column_q;
		end
		new_frame = is_sample && (r == '0) && (c == '0);
		w = new_frame ? clamp_geo(cfg_width, GeoW'(MaxWidth)) : cur_w_q;
		h = new_frame ? clamp_geo(cfg_height, GeoW'(MaxHeight)) : cur_h_q;
		do_step   = is_sample || (in_row_q == cur_h_q);
		last_emit = !is_sample && (in_row_q > cur_h_q);

		ctl = '0;
		ctl.emit = EMIT_NONE;
		y = '0;
		x = '0;
		if (last_emit) begin
			ctl.emit = EMIT_LAST;
			y = h - GeoW'(1);
			x = w - GeoW'(1);
		end else if (do_step) begin
			if ((c == '0) && (r >= RowW'(2))) begin
				ctl.emit = EMIT_LAST;
				y = r - RowW'(2);
				x = w - GeoW'(1);
			end else if ((c != '0) && (r >= RowW'(1))) begin
				ctl.emit = EMIT_CUR;
				y = r - RowW'(1);
				x = GeoW'(c) - GeoW'(1);
			end
		end
		ctl.step      = do_step && !last_emit;
		ctl.store     = is_sample;
		ctl.par       = r[0];
		ctl.addr      = c;
		ctl.bottom    = is_sample ? in_item.raw_sample : 8'd0;
		ctl.label_on  = (in_item.scene_label != '0);
		ctl.top_ok    = (r >= RowW'(2));
		ctl.mid_ok    = (r >= RowW'(1));
		ctl.y_odd     = y[0];
		ctl.x_odd     = x[0];
		ctl.top       = (y < GeoW'(2));
		ctl.bot       = (y >= h - GeoW'(2));
		ctl.lft       = (x < GeoW'(2));
		ctl.rgt       = (x >= w - GeoW'(2));
		ctl.frame_end = (y == h - GeoW'(1)) && (x == w - GeoW'(1));

		c_next = GeoW'(c) + GeoW'(1);
		row_nx = in_row_q;
		col_nx = in_column_q;
		if (last_emit) begin
			row_nx = '0;
			col_nx = '0;
		end else if (do_step) begin
			if (c_next >= w) begin
				col_nx = '0;
				row_nx = r + RowW'(1);
			end else begin
				col_nx = c_next[AddrW-1:0];
				row_nx = r;
			end
		end
		rd_addr = c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q    <= '0;
			in_column_q <= '0;
			cur_w_q     <= ResetWidth;
			cur_h_q     <= ResetHeight;
			v_s1        <= 1'b0;
		end else if (en) begin
			v_s1 <= accept && (ctl.step || ctl.emit != EMIT_NONE);
			if (accept) begin
				in_row_q    <= row_nx;
				in_column_q <= col_nx;
				if (new_frame) begin
					cur_w_q <= w;
					cur_h_q <= h;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1 <= ctl;
		end
	end

endmodule

// ===== hw/rtl/bdlm_interp.sv =====
// Window and interpolation stage: takes line-store read data, drives the
// line-store writes, shifts the window, computes the RGB pixel and holds
// it in the output register. Depends on bdlm_pkg.
module bdlm_interp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        v_s1,
	input  bdlm_pkg::stage_t            ctl_s1,
	input  logic [bdlm_pkg::WordW-1:0]  rd0,
	input  logic [bdlm_pkg::WordW-1:0]  rd1,
	output logic                        we0,
	output logic                        we1,
	output logic [bdlm_pkg::WordW-1:0]  wdata,
	output logic                        out_valid,
	output bdlm_pkg::out_item_t         out_item
);
	import bdlm_pkg::*;

	logic [7:0] win_q [3][2];
	logic       mask_q;

	logic [7:0]       top_w;
	logic [WordW-1:0] mid_w;
	logic [7:0] inc [3];
	logic [7:0] t_l, t_c, t_r, m_l, m_c, m_r, b_l, b_c, b_r;
	logic [7:0] rr, gg, bb;
	logic       use_cur;
	out_item_t  px;

	always_comb begin
		top_w  = ctl_s1.par ? rd1[7:0] : rd0[7:0];
		mid_w  = ctl_s1.par ? rd0 : rd1;
		inc[0] = ctl_s1.top_ok ? top_w : 8'd0;
		inc[1] = ctl_s1.mid_ok ? mid_w[7:0] : 8'd0;
		inc[2] = ctl_s1.bottom;
		use_cur = (ctl_s1.emit == EMIT_CUR);
		t_l = win_q[0][0];
		t_c = win_q[0][1];
		t_r = use_cur ? inc[0] : 8'd0;
		m_l = win_q[1][0];
		m_c = win_q[1][1];
		m_r = use_cur ? inc[1] : 8'd0;
		b_l = win_q[2][0];
		b_c = win_q[2][1];
		b_r = use_cur ? inc[2] : 8'd0;

		if (!ctl_s1.y_odd) begin
			if (!ctl_s1.x_odd) begin
				gg = m_c;
				rr = ctl_s1.lft ? m_r : avg2(m_l, m_r);
				if (ctl_s1.top || (ctl_s1.rgt && !ctl_s1.bot) || (ctl_s1.lft && ctl_s1.bot)) begin
					bb = b_c;
				end else begin
					bb = avg2(t_c, b_c);
				end
			end else begin
				rr = m_c;
				if (ctl_s1.rgt && !ctl_s1.bot) begin
					gg = avg2(m_l, b_c);
					bb = b_l;
				end else if (ctl_s1.rgt) begin
					gg = avg3(m_l, b_c, t_c);
					bb = avg2(t_l, b_l);
				end else if (ctl_s1.top) begin
					gg = avg3(m_l, m_r, b_c);
					bb = avg2(b_l, b_r);
				end else begin
					gg = avg4(m_l, m_r, b_c, t_c);
					bb = avg4(b_l, b_r, t_l, t_r);
				end
			end
		end else begin
			if (!ctl_s1.x_odd) begin
				bb = m_c;
				if (ctl_s1.bot && ctl_s1.lft) begin
					rr = t_r;
					gg = avg2(t_c, m_r);
				end else if (ctl_s1.bot) begin
					rr = avg2(t_l, t_r);
					gg = avg3(t_c, m_l, m_r);
				end else if (ctl_s1.lft) begin
					rr = avg2(t_r, b_r);
					gg = avg3(t_c, m_r, b_c);
				end else begin
					rr = avg4(t_l, t_r, b_l, b_r);
					gg = avg4(t_c, b_c, m_l, m_r);
				end
			end else begin
				gg = m_c;
				rr = ctl_s1.bot ? t_c : avg2(t_c, b_c);
				bb = ctl_s1.rgt ? m_l : avg2(m_l, m_r);
			end
		end

		px.red       = mask_q ? rr : 8'd0;
		px.green     = mask_q ? gg : 8'd0;
		px.blue      = mask_q ? bb : 8'd0;
		px.frame_end = ctl_s1.frame_end;

		we0   = en && v_s1 && ctl_s1.store && !ctl_s1.par;
		we1   = en && v_s1 && ctl_s1.store && ctl_s1.par;
		wdata = {ctl_s1.label_on, ctl_s1.bottom};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				win_q[k][0] <= 8'd0;
				win_q[k][1] <= 8'd0;
			end
			mask_q    <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v_s1 && (ctl_s1.emit != EMIT_NONE);
			if (v_s1 && ctl_s1.step) begin
				for (int k = 0; k < 3; k++) begin
					win_q[k][0] <= win_q[k][1];
					win_q[k][1] <= inc[k];
				end
				mask_q <= mid_w[WordW-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_item <= px;
		end
	end

endmodule
